// ----- rtl/dsrq_pkg.sv -----
// shared types and constants for the depth sort render queue
// no dependencies
`default_nettype none
package dsrq_pkg;
  localparam int DEFAULT_MAX_ENTRIES = 64;
  localparam int IDX_W = 6;
  localparam int KEY_W = 32;
  localparam int DROP_W = 8;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_TRI   = 2'd2;
  localparam logic [1:0] KIND_QUAD  = 2'd3;

  typedef struct packed {
    logic [1:0]         elem_kind;
    logic signed [31:0] depth_a;
    logic signed [31:0] depth_b;
    logic signed [31:0] depth_c;
    logic signed [31:0] depth_d;
    logic               end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] average_depth;
    logic [DROP_W-1:0]       dropped_pushes;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    eof;
  } q_entry_t;
endpackage
`default_nettype wire

// ----- rtl/dsrq_front.sv -----
// front end: captures an element and computes its floored average depth key
// depends on dsrq_pkg
`default_nettype none
module dsrq_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire dsrq_pkg::in_item_t in_item,
  output logic                   busy,
  output logic                   fr_valid,
  input  wire logic              fr_ready,
  output dsrq_pkg::q_entry_t     fr_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;
  localparam logic [34:0] DIV_BIAS = 35'h6_0000_0000; // 3 * 2^33

  logic [1:0] state_r, state_nxt;
  dsrq_pkg::in_item_t item_r;
  logic [34:0] num_r, quo_r;
  logic [1:0] rem_r;
  logic [2:0] step_r;
  logic signed [31:0] key_r;
  logic signed [33:0] sum_nxt;
  logic [34:0] num_nxt, quo_nxt;
  logic [1:0] rem_nxt;
  logic [2:0] t;

  assign busy = (state_r != ST_IDLE);
  assign fr_valid = (state_r == ST_OUT);
  assign fr_data.key = key_r;
  assign fr_data.eof = item_r.end_of_frame;

  always_comb begin
    sum_nxt = 34'(item_r.depth_a);
    if (item_r.elem_kind != dsrq_pkg::KIND_POINT) sum_nxt = sum_nxt + 34'(item_r.depth_b);
    if (item_r.elem_kind == dsrq_pkg::KIND_TRI || item_r.elem_kind == dsrq_pkg::KIND_QUAD)
      sum_nxt = sum_nxt + 34'(item_r.depth_c);
    if (item_r.elem_kind == dsrq_pkg::KIND_QUAD) sum_nxt = sum_nxt + 34'(item_r.depth_d);
  end

  // seven bits of long division by three per cycle
  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    t = 3'd0;
    for (int i = 0; i < 7; i++) begin
      t = {rem_nxt, num_nxt[34]};
      num_nxt = {num_nxt[33:0], 1'b0};
      if (t >= 3'd3) begin
        rem_nxt = 2'(t - 3'd3);
        quo_nxt = {quo_nxt[33:0], 1'b1};
      end else begin
        rem_nxt = t[1:0];
        quo_nxt = {quo_nxt[33:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = (item_r.elem_kind == dsrq_pkg::KIND_TRI) ? ST_DIV : ST_OUT;
      ST_DIV:  if (step_r == 3'd4) state_nxt = ST_OUT;
      ST_OUT:  if (fr_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) item_r <= in_item;
    if (state_r == ST_SUM) begin
      num_r <= 35'(sum_nxt) + DIV_BIAS;
      quo_r <= '0;
      rem_r <= '0;
      step_r <= '0;
      unique case (item_r.elem_kind)
        dsrq_pkg::KIND_POINT: key_r <= 32'(sum_nxt);
        dsrq_pkg::KIND_LINE:  key_r <= 32'(sum_nxt >>> 1);
        dsrq_pkg::KIND_QUAD:  key_r <= 32'(sum_nxt >>> 2);
        default:              key_r <= '0;
      endcase
    end
    if (state_r == ST_DIV) begin
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      step_r <= step_r + 3'd1;
      // low word of quotient minus 2^33 equals the low word of the quotient
      if (step_r == 3'd4) key_r <= quo_nxt[31:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/dsrq_fifo.sv -----
// two-entry queue between front and back
// depends on dsrq_pkg
`default_nettype none
module dsrq_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire dsrq_pkg::q_entry_t wr_data,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output dsrq_pkg::q_entry_t      rd_data
);
  dsrq_pkg::q_entry_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

// ----- rtl/dsrq_back.sv -----
// back end: sorted insertion chain, drop counting and frame emission
// depends on dsrq_pkg
`default_nettype none
module dsrq_back #(
  parameter int MAX_ENTRIES = dsrq_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               asc,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire dsrq_pkg::q_entry_t q_data,
  output logic                    out_valid,
  output dsrq_pkg::out_item_t     out_item
);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic ST_INS = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic signed [31:0] key_r [MAX_ENTRIES];
  logic [dsrq_pkg::IDX_W-1:0] idx_r [MAX_ENTRIES];
  logic [CW-1:0] count_r, rem_r, count_after;
  logic [7:0] drop_r;
  logic state_r;
  logic [MAX_ENTRIES-1:0] keep;
  logic pop, ins;

  assign q_ready = (state_r == ST_INS);
  assign pop = q_valid && q_ready;
  assign ins = pop && (count_r < CW'(MAX_ENTRIES));
  assign count_after = ins ? count_r + CW'(1) : count_r;

  // cells that stay put: valid and not passed by the new key
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      keep[i] = (CW'(i) < count_r) &&
                (asc ? (key_r[i] <= q_data.key) : (key_r[i] >= q_data.key));
    end
  end

  assign out_valid = (state_r == ST_EMIT);
  assign out_item.entry_index = idx_r[0];
  assign out_item.average_depth = key_r[0];
  assign out_item.dropped_pushes = drop_r;
  assign out_item.last_of_run = (rem_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INS;
      count_r <= '0;
      drop_r <= '0;
      rem_r <= '0;
    end else if (state_r == ST_INS) begin
      if (pop) begin
        count_r <= count_after;
        if (!ins && drop_r != 8'd255) drop_r <= drop_r + 8'd1;
        if (q_data.eof) begin
          if (count_after == '0) begin
            drop_r <= '0;
          end else begin
            state_r <= ST_EMIT;
            rem_r <= count_after;
          end
        end
      end
    end else begin
      rem_r <= rem_r - CW'(1);
      if (rem_r == CW'(1)) begin
        state_r <= ST_INS;
        count_r <= '0;
        drop_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (state_r == ST_EMIT) begin
        if (i < MAX_ENTRIES - 1) begin
          key_r[i] <= key_r[(i + 1) % MAX_ENTRIES];
          idx_r[i] <= idx_r[(i + 1) % MAX_ENTRIES];
        end
      end else if (ins && !keep[i]) begin
        if (i == 0 || keep[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]) begin
          key_r[i] <= q_data.key;
          idx_r[i] <= dsrq_pkg::IDX_W'(count_r);
        end else begin
          key_r[i] <= key_r[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
          idx_r[i] <= idx_r[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/depth_sort_render_queue_unit.sv -----
// top level of the depth sort render queue
// depends on dsrq_pkg, dsrq_front, dsrq_fifo, dsrq_back
//
// usage
//   in channel: drive in_item and pulse start while busy is low; one beat
//   is taken at each edge with start high and busy low
//   front end: busy until the key is taken; point, line and quad pass sum
//   and out, a triangle also a divide by three, 7 quotient bits per cycle
//   back end: one insert per cycle into a sorted cell chain, none in emit
//   end of frame: after its own insert or drop the frame streams out on
//   out_valid, one beat per cycle and per stored entry; the queue keeps
//   taking the front end's keys meanwhile until its two slots fill
//   out channel: out_valid marks each beat for one cycle; no stall exists
//   cfg channel: cfg_ready is always high; write only while idle
//   reset: sort order descending, store and drop count empty
`default_nettype none
module depth_sort_render_queue_unit #(
  parameter int MAX_ENTRIES = dsrq_pkg::DEFAULT_MAX_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire dsrq_pkg::in_item_t in_item,
  output logic                    out_valid,
  output dsrq_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);
  logic asc_r;
  logic fr_valid, fr_ready, q_valid, q_ready;
  dsrq_pkg::q_entry_t fr_data, q_data;

  // sort order register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asc_r <= 1'b0;
    end else if (cfg_valid) begin
      asc_r <= cfg_data;
    end
  end

  dsrq_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item), .busy(busy),
    .fr_valid(fr_valid), .fr_ready(fr_ready), .fr_data(fr_data)
  );

  dsrq_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(fr_valid), .wr_ready(fr_ready),
    .wr_data(fr_data), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  dsrq_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .asc(asc_r), .q_valid(q_valid), .q_ready(q_ready),
    .q_data(q_data), .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for depth_sort_render_queue_unit
// depends on dsrq_pkg and the rtl of the block; checks results against its own frame sorter
`timescale 1ns / 1ps
module testbench;

  localparam int CAPACITY   = dsrq_pkg::DEFAULT_MAX_ENTRIES;
  localparam int SETTLE     = 30;    // front end plus insert chain, rounded up
  localparam int STALL_MAX  = 2000;  // cycles with no beat anywhere

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  dsrq_pkg::in_item_t  in_item = '0;
  logic      out_valid;
  dsrq_pkg::out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  depth_sort_render_queue_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stimulus and model state
  dsrq_pkg::in_item_t  pending_items[$];
  dsrq_pkg::out_item_t sorted_due[$];
  logic signed [31:0] frame_keys[$];
  int        drop_count = 0;
  logic      ascending_mode = 1'b0;
  bit        no_gaps = 0;
  bit        failed = 0;
  int        gap_left = 0;
  int        quiet_cycles = 0;

  // floor of the mean over the kind's vertex count
  function automatic logic signed [31:0] mean_depth(dsrq_pkg::in_item_t it);
    longint sum;
    longint q;
    int n;
    n = int'(it.elem_kind) + 1;
    sum = longint'(it.depth_a);
    if (n > 1) sum += longint'(it.depth_b);
    if (n > 2) sum += longint'(it.depth_c);
    if (n > 3) sum += longint'(it.depth_d);
    q = sum / n;
    if ((sum % n) != 0 && sum < 0) q -= 1;
    return q[31:0];
  endfunction

  // take one element into the frame store and, on frame end, queue the sorted run
  task automatic absorb_element(dsrq_pkg::in_item_t it);
    logic signed [31:0] keys[$];
    int order[$];
    int j;
    dsrq_pkg::out_item_t r;
    if (frame_keys.size() < CAPACITY) frame_keys.push_back(mean_depth(it));
    else if (drop_count < 255) drop_count++;
    if (it.end_of_frame) begin
      // stable insertion: strict compare keeps push order on ties
      for (int i = 0; i < frame_keys.size(); i++) begin
        j = order.size();
        while (j > 0 && (ascending_mode ? frame_keys[i] < frame_keys[order[j-1]]
                                        : frame_keys[i] > frame_keys[order[j-1]]))
          j--;
        order.insert(j, i);
      end
      for (int i = 0; i < order.size(); i++) begin
        r.entry_index    = order[i][5:0];
        r.average_depth  = frame_keys[order[i]];
        r.dropped_pushes = drop_count[7:0];
        r.last_of_run    = (i == order.size() - 1);
        sorted_due.push_back(r);
      end
      frame_keys.delete();
      drop_count = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one beat per start/busy handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) absorb_element(in_item);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          start <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // config channel: register beat lands in the model
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      ascending_mode <= cfg_data;
      cfg_valid <= 1'b0;
    end
  end

  // monitor: results cannot be stalled, compare every strobed beat
  always @(posedge clk) begin
    dsrq_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (sorted_due.size() == 0) begin
        $error("result beat with nothing expected: index %0d key %0d",
               out_item.entry_index, out_item.average_depth);
        failed = 1;
      end else begin
        want = sorted_due.pop_front();
        if (out_item.entry_index !== want.entry_index) begin
          $error("entry_index expected %0d got %0d", want.entry_index, out_item.entry_index);
          failed = 1;
        end
        if (out_item.average_depth !== want.average_depth) begin
          $error("average_depth expected %0d got %0d",
                 want.average_depth, out_item.average_depth);
          failed = 1;
        end
        if (out_item.dropped_pushes !== want.dropped_pushes) begin
          $error("dropped_pushes expected %0d got %0d",
                 want.dropped_pushes, out_item.dropped_pushes);
          failed = 1;
        end
        if (out_item.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0d got %0d", want.last_of_run, out_item.last_of_run);
          failed = 1;
        end
      end
    end
  end

  // watchdog: any accepted beat resets the count
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [31:0] random_depth();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return ($urandom_range(0, 6) - 3) <<< 16;   // coarse values, many ties
      4: return $urandom_range(0, 7) - 4;                // tiny, exercises floor
      default: return $urandom;
    endcase
  endfunction

  function automatic dsrq_pkg::in_item_t make_item(logic [1:0] kind, logic signed [31:0] a,
                                                   logic signed [31:0] b,
                                                   logic signed [31:0] c,
                                                   logic signed [31:0] d, logic eof);
    dsrq_pkg::in_item_t it;
    it.elem_kind = kind;
    it.depth_a = a;
    it.depth_b = b;
    it.depth_c = c;
    it.depth_d = d;
    it.end_of_frame = eof;
    return it;
  endfunction

  task automatic queue_random_frame(int n);
    for (int i = 0; i < n; i++)
      pending_items.push_back(make_item(2'($urandom_range(0, 3)), random_depth(),
                                        random_depth(), random_depth(), random_depth(),
                                        i == n - 1));
  endtask

  // let the sender drain, then hold off until every result beat is in
  task automatic drain_all();
    while (pending_items.size() > 0 || start || gap_left > 0 || sorted_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(logic asc);
    @(posedge clk);
    cfg_data <= asc;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_valid);
  endtask

  localparam logic signed [31:0] DMAX = 32'sh7fffffff;
  localparam logic signed [31:0] DMIN = 32'sh80000000;

  initial begin
    int total;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset order is descending; every kind, extremes, floor on negatives
    pending_items.push_back(make_item(dsrq_pkg::KIND_POINT, DMAX, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_LINE,  DMIN, DMIN, 0, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_TRI,   DMAX, DMAX, DMAX, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_QUAD,  DMIN, DMIN, DMIN, DMIN, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_TRI,   -32'sd1, 0, 0, DMAX, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_QUAD,  -32'sd5, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_LINE,  DMAX, DMIN, DMAX, DMIN, 1'b1));
    // equal keys from different kinds must keep push order
    pending_items.push_back(make_item(dsrq_pkg::KIND_POINT, 32'sh10000, DMIN, DMIN, DMIN,
                                      1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_LINE,  0, 32'sh20000, DMAX, DMAX, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_QUAD,  32'sh40000, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_TRI,   32'sh30000, 0, 0, -32'sd1, 1'b1));
    // single element frame
    pending_items.push_back(make_item(dsrq_pkg::KIND_POINT, -32'sd1, -32'sd1, -32'sd1,
                                      -32'sd1, 1'b1));
    drain_all();

    write_order(1'b1);
    pending_items.push_back(make_item(dsrq_pkg::KIND_POINT, 32'sh10000, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_TRI,   DMIN, DMAX, -32'sd7, 0, 1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_LINE,  32'sh10000, 32'sh10000, 0, 0,
                                      1'b0));
    pending_items.push_back(make_item(dsrq_pkg::KIND_QUAD,  DMAX, DMAX, DMAX, DMAX, 1'b1));
    drain_all();

    // random: exactly full store with the closing element dropped
    write_order(1'b0);
    queue_random_frame(CAPACITY + 1);
    drain_all();

    // long frame to push the drop count into saturation, back to back
    write_order(1'b1);
    no_gaps = 1;
    queue_random_frame(CAPACITY + 266);
    drain_all();
    no_gaps = 0;

    // short frames with order flips and mixed idling
    total = CAPACITY + 1 + CAPACITY + 266;
    while (total < 400) begin
      write_order(1'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int f = 0; f < 3; f++) begin
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        queue_random_frame(n);
        total += n;
      end
      drain_all();
    end

    if (!failed && sorted_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sorted_due.size() != 0) $error("%0d result beats never arrived", sorted_due.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/dsrq_pkg.sv
rtl/dsrq_front.sv
rtl/dsrq_fifo.sv
rtl/dsrq_back.sv
rtl/depth_sort_render_queue_unit.sv
tb/testbench.sv
